// ===== rtl/vsst_pkg.sv =====
// ----------------------------------------------------------------------------
// vsst_pkg
// shared types and constants for the step-toward vector block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsst_pkg;

	// step length register width, fixed by the register map
	localparam int STEP_W = 15;

	// configuration register index
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_X    = 2'd0,
		REG_TARGET_Y    = 2'd1,
		REG_STEP_LENGTH = 2'd2
	} vsst_reg_t;

	// request mode codes
	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_TICK = 1'b1
	} vsst_mode_t;

	// countdown for the serial step multiplier
	localparam int PCNT_W = $clog2(STEP_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_ROOT,
		ST_CHECK,
		ST_DIV,
		ST_APPLY,
		ST_OUT
	} vsst_state_t;

endpackage

// ===== rtl/vsst_item_if.sv =====
// ----------------------------------------------------------------------------
// vsst_item_if
// request channel: load or tick request with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vsst_item_if #(
	parameter int VALUE_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [VALUE_WIDTH-1:0] load_x;
	logic [VALUE_WIDTH-1:0] load_y;
	logic                   active;

	modport source (output valid, output mode, output load_x, output load_y,
		output active, input ready);
	modport sink (input valid, input mode, input load_x, input load_y,
		input active, output ready);
endinterface

// ===== rtl/vsst_result_if.sv =====
// ----------------------------------------------------------------------------
// vsst_result_if
// result channel: current value and done flag with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vsst_result_if #(
	parameter int VALUE_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] cur_x;
	logic [VALUE_WIDTH-1:0] cur_y;
	logic                   done_res;

	modport source (output valid, output cur_x, output cur_y, output done_res,
		input ready);
	modport sink (input valid, input cur_x, input cur_y, input done_res,
		output ready);
endinterface

// ===== rtl/vector_scale_step_toward.sv =====
// ----------------------------------------------------------------------------
// vector_scale_step_toward
// sequence: a load, an inactive tick or a tick after done goes from idle
//   straight to the output state; a tick that snaps onto the target passes
//   the squares, root and check states first, and a moving tick also the
//   divide and apply states, set by the bit-serial squares, root and divide
//   loops; the output state waits while the result side holds the register
// requests: one at a time, the next is taken once the block is back in
//   idle, as the result is registered; reset puts the value at 256, 256 and clears done
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_scale_step_toward #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [vsst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [((VALUE_WIDTH > vsst_pkg::STEP_W) ? VALUE_WIDTH
		: vsst_pkg::STEP_W)-1:0]                   cfg_data,
	vsst_item_if.sink                             item,
	vsst_result_if.source                         result
);
	import vsst_pkg::*;

	// widths of the serial datapath
	localparam int W     = VALUE_WIDTH;
	localparam int DW    = W + 1;          // root (distance) width
	localparam int SW    = 2 * W + 2;      // sum of squares, padded to even
	localparam int PW    = W + STEP_W;     // step times offset
	localparam int CW    = $clog2(W + 2);  // loop counter
	localparam int MW    = (DW > STEP_W) ? DW : STEP_W;
	localparam logic [W-1:0] RESET_VAL = W'(256);
	localparam logic [STEP_W-1:0] RESET_STEP = STEP_W'(16);

	// configuration registers
	logic [W-1:0]      tgt_x_q, tgt_y_q;
	logic [STEP_W-1:0] step_q;

	// architectural state
	logic [W-1:0] cur_x_q, cur_y_q;
	logic         reached_q;

	// control
	vsst_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic take, move_start, out_load;

	// offset signs of the move in progress
	logic         sgnx_q, sgny_q;

	// squares unit: shift-add of ax*ax + ay*ay, one multiplier bit a cycle
	logic [W-1:0]  sbx_q, sby_q;
	logic [SW-1:0] smx_q, smy_q, sum_q;

	// step multiplier: step*ax and step*ay, one step bit a cycle
	logic [STEP_W-1:0] pst_q;
	logic [PW-1:0]     pmx_q, pmy_q, nx_q, ny_q;
	logic [PCNT_W-1:0] pcnt_q;

	// square root: restoring digit recurrence, one root bit a cycle
	logic [W+1:0] rrem_q;
	logic [DW-1:0] root_q;

	// dividers: remainder and dividend/quotient shift registers
	logic [DW-1:0] drx_q, dry_q;
	logic [W-1:0]  dqx_q, dqy_q;

	// output register
	logic         res_valid_q;
	logic [W-1:0] res_x_q, res_y_q;
	logic         res_done_q;

	// offsets from the current value to the target at request time
	logic signed [W:0] dx_c, dy_c;
	logic [W:0]        ndx_c, ndy_c;
	logic [W-1:0]      ax_c, ay_c;

	assign dx_c  = $signed({tgt_x_q[W-1], tgt_x_q}) - $signed({cur_x_q[W-1], cur_x_q});
	assign dy_c  = $signed({tgt_y_q[W-1], tgt_y_q}) - $signed({cur_y_q[W-1], cur_y_q});
	assign ndx_c = -dx_c;
	assign ndy_c = -dy_c;
	assign ax_c  = dx_c[W] ? ndx_c[W-1:0] : dx_c[W-1:0];
	assign ay_c  = dy_c[W] ? ndy_c[W-1:0] : dy_c[W-1:0];

	// root step: bring down two radicand bits, try root*4+1
	logic [W+3:0] rem2_c, trial_c;
	logic         rfit_c;

	assign rem2_c  = {rrem_q, sum_q[SW-1:SW-2]};
	assign trial_c = (W+4)'({root_q, 2'b01});
	assign rfit_c  = rem2_c >= trial_c;

	// divide step: bring down one dividend bit, try the distance
	logic [DW:0] drx2_c, dry2_c;
	logic        qx_c, qy_c;

	assign drx2_c = {drx_q, dqx_q[W-1]};
	assign dry2_c = {dry_q, dqy_q[W-1]};
	assign qx_c   = drx2_c >= {1'b0, root_q};
	assign qy_c   = dry2_c >= {1'b0, root_q};

	// signed moves from the quotients
	logic [W:0] qx_e, qy_e, mvx_c, mvy_c;

	assign qx_e  = {1'b0, dqx_q};
	assign qy_e  = {1'b0, dqy_q};
	assign mvx_c = sgnx_q ? -qx_e : qx_e;
	assign mvy_c = sgny_q ? -qy_e : qy_e;

	// snap when the distance is zero or shorter than one step
	logic snap_c;

	assign snap_c = (root_q == '0) || (MW'(root_q) < MW'(step_q));

	// request side is open whenever no request is in flight
	assign item.ready      = (state_q == ST_IDLE);
	assign result.valid    = res_valid_q;
	assign result.cur_x    = res_x_q;
	assign result.cur_y    = res_y_q;
	assign result.done_res = res_done_q;

	// ---------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		take       = 1'b0;
		move_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take = item.valid;
				if (item.valid) begin
					// only an active tick that is not yet done moves
					if (item.mode == MODE_TICK && item.active && !reached_q) begin
						move_start = 1'b1;
						state_d    = ST_SQR;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SQR: begin
				if (cnt_q == CW'(1)) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (cnt_q == CW'(1)) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = snap_c ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CW'(1)) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hand the result over once the output register is free
				if (!res_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// configuration and architectural state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q   <= RESET_VAL;
			tgt_y_q   <= RESET_VAL;
			step_q    <= RESET_STEP;
			cur_x_q   <= RESET_VAL;
			cur_y_q   <= RESET_VAL;
			reached_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_TARGET_X:    tgt_x_q <= cfg_data[W-1:0];
					REG_TARGET_Y:    tgt_y_q <= cfg_data[W-1:0];
					REG_STEP_LENGTH: step_q  <= cfg_data[STEP_W-1:0];
					default: ;  // unmapped index, write dropped
				endcase
			end
			// load applies whatever active says, and clears done
			if (take && item.mode == MODE_LOAD) begin
				cur_x_q   <= item.load_x;
				cur_y_q   <= item.load_y;
				reached_q <= 1'b0;
			end
			if (state_q == ST_CHECK && snap_c) begin
				cur_x_q   <= tgt_x_q;
				cur_y_q   <= tgt_y_q;
				reached_q <= 1'b1;
			end
			if (state_q == ST_APPLY) begin
				cur_x_q <= cur_x_q + mvx_c[W-1:0];
				cur_y_q <= cur_y_q + mvy_c[W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// loop counters and output valid
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			priority if (move_start) begin
				cnt_q <= CW'(W);
			end else if (state_q == ST_SQR && cnt_q == CW'(1)) begin
				cnt_q <= CW'(DW);
			end else if (state_q == ST_CHECK) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end

			// step multiplier runs alongside squares and root; it is
			// done long before the divide needs it
			if (move_start) begin
				pcnt_q <= PCNT_W'(STEP_W);
			end else if (pcnt_q != '0) begin
				pcnt_q <= pcnt_q - PCNT_W'(1);
			end

			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// serial datapath
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (move_start) begin
			sgnx_q <= dx_c[W];
			sgny_q <= dy_c[W];
			sbx_q  <= ax_c;
			sby_q  <= ay_c;
			smx_q  <= SW'(ax_c);
			smy_q  <= SW'(ay_c);
			sum_q  <= '0;
			pst_q  <= step_q;
			pmx_q  <= PW'(ax_c);
			pmy_q  <= PW'(ay_c);
			nx_q   <= '0;
			ny_q   <= '0;
		end else begin
			// sum of squares, lowest multiplier bit first
			if (state_q == ST_SQR) begin
				sum_q <= sum_q + (sbx_q[0] ? smx_q : '0) + (sby_q[0] ? smy_q : '0);
				sbx_q <= sbx_q >> 1;
				sby_q <= sby_q >> 1;
				smx_q <= smx_q << 1;
				smy_q <= smy_q << 1;
			end

			// radicand leaves from the top, two bits a cycle
			if (state_q == ST_ROOT) begin
				sum_q <= sum_q << 2;
			end

			if (pcnt_q != '0) begin
				nx_q  <= nx_q + (pst_q[0] ? pmx_q : '0);
				ny_q  <= ny_q + (pst_q[0] ? pmy_q : '0);
				pst_q <= pst_q >> 1;
				pmx_q <= pmx_q << 1;
				pmy_q <= pmy_q << 1;
			end
		end

		if (state_q == ST_SQR) begin
			rrem_q <= '0;
			root_q <= '0;
		end else if (state_q == ST_ROOT) begin
			if (rfit_c) begin
				rrem_q <= (W+2)'(rem2_c - trial_c);
				root_q <= {root_q[DW-2:0], 1'b1};
			end else begin
				rrem_q <= rem2_c[W+1:0];
				root_q <= {root_q[DW-2:0], 1'b0};
			end
		end

		// quotient fits W bits since step <= distance; the upper product
		// bits therefore start out below the distance
		if (state_q == ST_CHECK) begin
			drx_q <= DW'(nx_q >> W);
			dry_q <= DW'(ny_q >> W);
			dqx_q <= nx_q[W-1:0];
			dqy_q <= ny_q[W-1:0];
		end else if (state_q == ST_DIV) begin
			drx_q <= qx_c ? DW'(drx2_c - {1'b0, root_q}) : drx2_c[DW-1:0];
			dry_q <= qy_c ? DW'(dry2_c - {1'b0, root_q}) : dry2_c[DW-1:0];
			dqx_q <= {dqx_q[W-2:0], qx_c};
			dqy_q <= {dqy_q[W-2:0], qy_c};
		end

		if (out_load) begin
			res_x_q    <= cur_x_q;
			res_y_q    <= cur_y_q;
			res_done_q <= reached_q;
		end
	end

endmodule
